// File: src/bq_pkg.sv
// Shared constants and register codes for the four-channel biquad low-pass.
// No dependencies; compiled before every other file.
package bq_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int COEF_WIDTH         = 20;
    localparam int CHANNELS           = 4;
    localparam int COEF_COUNT         = 5;
    localparam int APB_DATA_WIDTH     = 32;
    localparam int APB_ADDR_WIDTH     = 5;

    // coefficient register index, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

endpackage

// File: src/bq_if.sv
// Valid/ready channel interfaces for the biquad sample and result words.
// Depends on bq_pkg for the default sample width.
interface bq_in_if
    import bq_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] azimuth_in;
    logic signed [W-1:0] elevation_in;
    logic signed [W-1:0] length_in;
    logic signed [W-1:0] tension_in;

    modport source (output valid, azimuth_in, elevation_in, length_in, tension_in,
                    input ready);
    modport sink   (input valid, azimuth_in, elevation_in, length_in, tension_in,
                    output ready);
endinterface

interface bq_out_if
    import bq_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] azimuth_out;
    logic signed [W-1:0] elevation_out;
    logic signed [W-1:0] length_out;
    logic signed [W-1:0] tension_out;

    modport source (output valid, azimuth_out, elevation_out, length_out, tension_out,
                    input ready);
    modport sink   (input valid, azimuth_out, elevation_out, length_out, tension_out,
                    output ready);
endinterface

// File: src/biquad_lowpass_four_channel.sv
// Four-channel direct form I biquad low-pass, top level with APB coefficient port.
// Depends on bq_pkg and the channel interfaces in bq_if.sv.
//
//  channel   dir  handshake        payload
//  i_smp     in   valid/ready      azimuth/elevation/length/tension_in, signed
//  o_flt     out  valid/ready      azimuth/elevation/length/tension_out, saturated
//  apb       in   psel/penable     five signed coefficient registers at 4*index
//
// One word per cycle sustained while the receiver is ready; a word passes the
// input register, then the result register. The y1 feedback is combinational:
// five products, a sum, round and saturate per channel between the input register
// and the delay state. Reset clears delay lines, valids and coefficients (b0 = 1.0)
// at once. A stalled result holds in the output register while one more word waits
// in the input register.
module biquad_lowpass_four_channel
    import bq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bq_in_if.sink                     i_smp,
    bq_out_if.source                  o_flt,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    // sample width is fixed by the channel interfaces
    localparam int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF;
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [COEF_WIDTH-1:0] B0_RESET =
        COEF_WIDTH'(64'sd1 <<< COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    // ---------------- coefficient registers ----------------
    logic signed [COEF_WIDTH-1:0] r_cb0, r_cb1, r_cb2, r_ca1, r_ca2;
    logic                         cfg_wr;
    t_reg_idx                     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb0 <= B0_RESET;
            r_cb1 <= '0;
            r_cb2 <= '0;
            r_ca1 <= '0;
            r_ca2 <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_B0:  r_cb0 <= pwdata[COEF_WIDTH-1:0];
                REG_B1:  r_cb1 <= pwdata[COEF_WIDTH-1:0];
                REG_B2:  r_cb2 <= pwdata[COEF_WIDTH-1:0];
                REG_A1:  r_ca1 <= pwdata[COEF_WIDTH-1:0];
                REG_A2:  r_ca2 <= pwdata[COEF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_B0:  prdata = APB_DATA_WIDTH'(r_cb0);
            REG_B1:  prdata = APB_DATA_WIDTH'(r_cb1);
            REG_B2:  prdata = APB_DATA_WIDTH'(r_cb2);
            REG_A1:  prdata = APB_DATA_WIDTH'(r_ca1);
            REG_A2:  prdata = APB_DATA_WIDTH'(r_ca2);
            default: prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic r_in_valid, r_out_valid;
    logic advance, fire;

    assign advance     = !r_out_valid || o_flt.ready;
    assign fire        = r_in_valid && advance;
    assign i_smp.ready = !r_in_valid || advance;

    logic signed [SAMPLE_WIDTH-1:0] r_in_x [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_x1   [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_x2   [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_y1   [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_y2   [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_out_y[CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] n_y    [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_in_x[0] <= i_smp.azimuth_in;
            r_in_x[1] <= i_smp.elevation_in;
            r_in_x[2] <= i_smp.length_in;
            r_in_x[3] <= i_smp.tension_in;
        end
    end

    // ---------------- filter datapath ----------------
    always_comb begin
        logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
        logic signed [ACC_W-1:0]  acc, shr;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            p_b0 = r_cb0 * r_in_x[ch];
            p_b1 = r_cb1 * r_x1[ch];
            p_b2 = r_cb2 * r_x2[ch];
            p_a1 = r_ca1 * r_y1[ch];
            p_a2 = r_ca2 * r_y2[ch];
            acc  = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
                 - ACC_W'(p_a1) - ACC_W'(p_a2) + RND_HALF;
            shr  = acc >>> COEF_FRAC_BITS;
            if (shr > SAT_MAX) begin
                n_y[ch] = SAT_MAX[SAMPLE_WIDTH-1:0];
            end else if (shr < SAT_MIN) begin
                n_y[ch] = SAT_MIN[SAMPLE_WIDTH-1:0];
            end else begin
                n_y[ch] = shr[SAMPLE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_x1[ch] <= '0;
                r_x2[ch] <= '0;
                r_y1[ch] <= '0;
                r_y2[ch] <= '0;
            end
        end else if (fire) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_x2[ch] <= r_x1[ch];
                r_x1[ch] <= r_in_x[ch];
                r_y2[ch] <= r_y1[ch];
                r_y1[ch] <= n_y[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_out_y[ch] <= n_y[ch];
            end
        end
    end

    assign o_flt.valid         = r_out_valid;
    assign o_flt.azimuth_out   = r_out_y[0];
    assign o_flt.elevation_out = r_out_y[1];
    assign o_flt.length_out    = r_out_y[2];
    assign o_flt.tension_out   = r_out_y[3];

    // ---------------- assertions ----------------
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid not cleared by reset");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_y1[0]) && $stable(r_x1[0]))
        else $error("delay state moved without a word");

    a_out_matches_y1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_y[0] == r_y1[0]) && (r_out_y[3] == r_y1[3]))
        else $error("held result differs from feedback state");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_x[0]))
        else $error("waiting input word overwritten");

endmodule

// File: sim/tb_biquad_lowpass_four_channel.sv
// Self-checking bench for the four-channel biquad low-pass: drives sample words and
// APB coefficient writes, predicts every filtered word and compares it field by field.
// Depends on bq_pkg, the channel interfaces in bq_if.sv and the RTL top level.
module tb_biquad_lowpass_four_channel;
    import bq_pkg::*;

    localparam int    SW            = SAMPLE_WIDTH_DEF;
    localparam int    FRAC          = COEF_FRAC_BITS_DEF;
    localparam int    STALL_LIMIT   = 5000;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    LONG_HOLD     = 200;
    localparam longint SAT_HI       = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAT_LO       = -(longint'(1) <<< (SW - 1));

    typedef logic [CHANNELS-1:0][SW-1:0] t_quad;   // [0] azimuth .. [3] tension
    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr   = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata  = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    bq_in_if  smp_if ();
    bq_out_if flt_if ();

    biquad_lowpass_four_channel u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_flt   (flt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // filter state as the block should hold it
    t_coef                coef_bank [COEF_COUNT];
    logic signed [SW-1:0] x_d1 [CHANNELS];
    logic signed [SW-1:0] x_d2 [CHANNELS];
    logic signed [SW-1:0] y_d1 [CHANNELS];
    logic signed [SW-1:0] y_d2 [CHANNELS];

    t_quad filtered_q [$];
    int    mismatches     = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    hold_cycles    = 0;
    int    idle_cycles    = 0;
    string out_names [CHANNELS] = '{"azimuth_out", "elevation_out", "length_out",
                                    "tension_out"};

    function automatic t_quad run_biquad(input t_quad x_in);
        t_quad                y_out;
        longint               acc;
        longint               y;
        logic signed [SW-1:0] x;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            x   = x_in[ch];
            acc = longint'(coef_bank[REG_B0]) * longint'(x)
                + longint'(coef_bank[REG_B1]) * longint'(x_d1[ch])
                + longint'(coef_bank[REG_B2]) * longint'(x_d2[ch])
                - longint'(coef_bank[REG_A1]) * longint'(y_d1[ch])
                - longint'(coef_bank[REG_A2]) * longint'(y_d2[ch]);
            // round half up, then floor shift
            acc = acc + (longint'(1) <<< (FRAC - 1));
            y   = acc >>> FRAC;
            if (y > SAT_HI)
                y = SAT_HI;
            else if (y < SAT_LO)
                y = SAT_LO;
            x_d2[ch]  = x_d1[ch];
            x_d1[ch]  = x;
            y_d2[ch]  = y_d1[ch];
            y_d1[ch]  = SW'(y);
            y_out[ch] = SW'(y);
        end
        return y_out;
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(7))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2: return SW'($urandom_range(3)) - SW'(1);
            default: return SW'($urandom);
        endcase
    endfunction

    // receiver: random stalls, long hold-off on request, checks each word
    always @(posedge i_clk) begin
        t_quad got;
        t_quad want;
        if (i_rst_n && flt_if.valid && flt_if.ready) begin
            got = {flt_if.tension_out, flt_if.length_out, flt_if.elevation_out,
                   flt_if.azimuth_out};
            if (filtered_q.size() == 0) begin
                $error("output word with nothing expected: %h", got);
                mismatches++;
            end else begin
                want = filtered_q.pop_front();
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (got[ch] !== want[ch]) begin
                        $error("%s: expected %0d, got %0d", out_names[ch],
                               $signed(want[ch]), $signed(got[ch]));
                        mismatches++;
                    end
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            flt_if.ready <= 1'b0;
        end else begin
            flt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) || (flt_if.valid && flt_if.ready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input t_quad w);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.azimuth_in   <= w[0];
        smp_if.elevation_in <= w[1];
        smp_if.length_in    <= w[2];
        smp_if.tension_in   <= w[3];
        @(posedge i_clk);
        while (!smp_if.ready)
            @(posedge i_clk);
        filtered_q.push_back(run_biquad(w));
    endtask

    // stop sending and let the pipeline drain
    task automatic wait_idle();
        smp_if.valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input int idx, input logic [APB_DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_WIDTH'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // leave the bus idle before the next transfer
        @(posedge i_clk);
    endtask

    // junk above the coefficient width must be dropped by the block
    task automatic write_coef(input t_reg_idx idx, input t_coef value);
        logic [APB_DATA_WIDTH-COEF_WIDTH-1:0] junk;
        junk = ($urandom_range(1) == 0) ? '0 : (APB_DATA_WIDTH-COEF_WIDTH)'($urandom);
        apb_write(int'(idx), {junk, value});
        coef_bank[idx] = value;
    endtask

    task automatic set_coefs(input t_coef b0, input t_coef b1, input t_coef b2,
                             input t_coef a1, input t_coef a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
    endtask

    task automatic send_random_run(input int count);
        t_quad level;
        t_quad w;
        for (int ch = 0; ch < CHANNELS; ch++)
            level[ch] = pick_sample();
        for (int n = 0; n < count; n++) begin
            // slowly stepping levels with small noise, now and then pure noise
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if ($urandom_range(3) == 0)
                    level[ch] = pick_sample();
                w[ch] = level[ch] + SW'($urandom_range(63)) - SW'(32);
            end
            if ($urandom_range(7) == 0)
                for (int ch = 0; ch < CHANNELS; ch++)
                    w[ch] = SW'($urandom);
            send_word(w);
        end
    endtask

    // reset coefficients give b0 = 1.0, so words come out unchanged
    task automatic test_passthrough();
        send_word({4{16'sh7fff}});
        send_word({4{16'sh8000}});
        send_word('0);
        send_word({4{16'shffff}});
        send_word({16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff});
        send_word({16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
        send_word({16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
    endtask

    task automatic test_register_map();
        wait_idle();
        // writes beyond the last register are dropped
        for (int k = COEF_COUNT; k < (1 << (APB_ADDR_WIDTH - 2)); k++)
            apb_write(k, $urandom);
        send_word({16'sh1234, 16'sh8001, 16'sh7ffe, 16'sh0100});
        send_word({16'sh0001, 16'shfffe, 16'sh4000, 16'shc000});
        wait_idle();
        set_coefs(20'sd32768, 20'sd16384, -20'sd8192, -20'sd32768, 20'sd8192);
        send_word({16'sh7fff, 16'sh8000, 16'sh0400, 16'shfc00});
        send_word({16'sh7fff, 16'sh8000, 16'sh0400, 16'shfc00});
        send_word('0);
        send_word({16'sh8000, 16'sh7fff, 16'shfc00, 16'sh0400});
    endtask

    task automatic test_saturation();
        wait_idle();
        set_coefs(20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh80000, 20'sh80000);
        repeat (3) send_word({4{16'sh7fff}});
        repeat (3) send_word({4{16'sh8000}});
        wait_idle();
        set_coefs(20'sh80000, 20'sh80000, 20'sh80000, 20'sh7ffff, 20'sh7ffff);
        send_word({16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff});
        send_word({16'sh8000, 16'sh7fff, 16'shffff, 16'sh0001});
        send_word('0);
    endtask

    task automatic test_random_phases();
        for (int s = 0; s < 5; s++) begin
            wait_idle();
            case (s)
                0: set_coefs(20'sd1317, 20'sd2634, 20'sd1317, -20'sd102302, 20'sd42035);
                1: set_coefs(20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
                2: set_coefs(20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000);
                3: set_coefs(t_coef'($urandom), t_coef'($urandom), t_coef'($urandom),
                             t_coef'($urandom), t_coef'($urandom));
                default: set_coefs(t_coef'($urandom_range(131072)) - t_coef'(65536),
                                   t_coef'($urandom_range(131072)) - t_coef'(65536),
                                   t_coef'($urandom_range(131072)) - t_coef'(65536),
                                   t_coef'($urandom_range(131072)) - t_coef'(65536),
                                   t_coef'($urandom_range(131072)) - t_coef'(65536));
            endcase
            for (int p = 0; p < 4; p++) begin
                case (p)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                    default: begin send_idle_pct = 28; recv_stall_pct = 28; end
                endcase
                send_random_run(25);
            end
        end
    endtask

    // receiver holds off while words keep coming, so both stages fill and input stalls
    task automatic test_backpressure();
        wait_idle();
        set_coefs(20'sd1317, 20'sd2634, 20'sd1317, -20'sd102302, 20'sd42035);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = LONG_HOLD;
        send_random_run(40);
    endtask

    initial begin
        smp_if.valid        = 1'b0;
        smp_if.azimuth_in   = '0;
        smp_if.elevation_in = '0;
        smp_if.length_in    = '0;
        smp_if.tension_in   = '0;
        flt_if.ready        = 1'b0;
        coef_bank[REG_B0]   = t_coef'(1 << FRAC);
        for (int i = 1; i < COEF_COUNT; i++)
            coef_bank[i] = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            x_d1[ch] = '0;
            x_d2[ch] = '0;
            y_d1[ch] = '0;
            y_d2[ch] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_register_map();
        test_saturation();
        test_random_phases();
        test_backpressure();

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: biquad_lowpass_four_channel.f
src/bq_pkg.sv
src/bq_if.sv
src/biquad_lowpass_four_channel.sv
sim/tb_biquad_lowpass_four_channel.sv
